// ===== hw/rtl/ifs_field_splitter_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef IFS_FIELD_SPLITTER_UNIT_DEFINES_SVH
`define IFS_FIELD_SPLITTER_UNIT_DEFINES_SVH

// Antecedent holds in a cycle, consequent in the same cycle.
`define IFS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent holds in a cycle, consequent in the next cycle.
`define IFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ifs_pkg.sv =====
package ifs_pkg;

  localparam int HOLD_DEPTH_DEF = 32;
  localparam int MAX_NAMES_DEF  = 16;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LC_R  = 8'h72;

  // Configuration register indexes
  localparam logic [2:0] CFG_MAP0  = 3'd0;
  localparam logic [2:0] CFG_MAP1  = 3'd1;
  localparam logic [2:0] CFG_MAP2  = 3'd2;
  localparam logic [2:0] CFG_MAP3  = 3'd3;
  localparam logic [2:0] CFG_RAW   = 3'd4;
  localparam logic [2:0] CFG_NAMES = 3'd5;

  // Reset delimiter set: space, tab, newline
  localparam logic [63:0] IFS_MAP0_RST = 64'h0000_0001_0000_0600;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_FIELD = 3'd1,
    PH_SEP1  = 3'd2,
    PH_SEP2  = 3'd3,
    PH_REM   = 3'd4
  } phase_t;

  typedef struct packed {
    logic       byte_v;
    logic       fend;
    logic [7:0] data;
    logic [7:0] idx;
  } res_t;

  typedef struct packed {
    logic accept;
    logic step_apply;
    logic flush_start;
    logic flush_emit;
    logic end_first;
    logic end_pad;
    logic release_pend;
  } cmd_t;

  typedef struct packed {
    logic sub_avail;
    logic do_end;
    logic flush_go;
    logic emit_need;
    logic slot_ok;
    logic flush_last;
    logic em_first;
    logic em_pad;
    logic pad_last;
  } sts_t;

endpackage

// ===== hw/rtl/ifs_ctrl.sv =====
module ifs_ctrl import ifs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_STEP  = 6'b000010,
    S_FLUSH = 6'b000100,
    S_ENDM  = 6'b001000,
    S_PAD   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Sequence the sub-bytes, hold releases and end marks of one transaction
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (!sts.sub_avail) begin
          state_next = sts.do_end ? S_ENDM : S_DONE;
        end else if (sts.flush_go) begin
          cmd.flush_start = 1'b1;
          state_next      = S_FLUSH;
        end else if (!sts.emit_need || sts.slot_ok) begin
          cmd.step_apply = 1'b1;
        end
      end
      S_FLUSH: begin
        if (sts.slot_ok) begin
          cmd.flush_emit = 1'b1;
          if (sts.flush_last) state_next = S_STEP;
        end
      end
      S_ENDM: begin
        if (!sts.em_first || sts.slot_ok) begin
          cmd.end_first = 1'b1;
          state_next    = sts.em_pad ? S_PAD : S_DONE;
        end
      end
      S_PAD: begin
        if (sts.slot_ok) begin
          cmd.end_pad = 1'b1;
          if (sts.pad_last) state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.slot_ok) begin
          cmd.release_pend = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/ifs_dp.sv =====
module ifs_dp import ifs_pkg::*; #(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
  parameter int MAX_NAMES  = MAX_NAMES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        line_end,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic [7:0]  field_index,
  output logic        byte_valid,
  output logic        field_end,
  output logic        hold_overflow,
  output logic        last
);

  localparam int         AW     = $clog2(HOLD_DEPTH);
  localparam logic [5:0] DEPTH6 = 6'(HOLD_DEPTH);
  localparam logic [4:0] MAXN5  = 5'(MAX_NAMES);

  // Configuration
  logic [255:0] ifs_map;
  logic         esc_bypass;
  logic [4:0]   name_count;
  logic [4:0]   n;

  // Line state
  logic         esc;
  phase_t       phase;
  logic [7:0]   cur;
  logic [7:0]   hold_mem [HOLD_DEPTH];
  logic [5:0]   hcnt;
  logic         hhas;
  logic         rhas;

  // Sub-bytes of the current transaction
  logic [7:0]   sa, sb;
  logic         sa_v, sb_v, do_end;
  logic         item_lost;
  logic [AW-1:0] fptr;
  logic [3:0]   pad_f;

  // Result staging
  res_t         pend;
  logic         pend_v;
  res_t         out_r;
  logic         out_last, out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      ifs_map    <= {192'd0, IFS_MAP0_RST};
      esc_bypass <= 1'b0;
      name_count <= 5'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAP0:  ifs_map[63:0]    <= cfg_data;
        CFG_MAP1:  ifs_map[127:64]  <= cfg_data;
        CFG_MAP2:  ifs_map[191:128] <= cfg_data;
        CFG_MAP3:  ifs_map[255:192] <= cfg_data;
        CFG_RAW:   esc_bypass       <= cfg_data[0];
        CFG_NAMES: name_count       <= cfg_data[4:0];
        default:   ;
      endcase
    end
  end

  assign n = (name_count > MAXN5) ? MAXN5 : name_count;

  // Classify the current sub-byte
  logic [7:0] b;
  logic       mem, wh;
  logic [7:0] inc;
  logic [8:0] cur9, nm1, start9;
  logic       n_ge2;

  assign b      = sa_v ? sa : sb;
  assign mem    = ifs_map[b];
  assign wh     = mem && (b == CH_SPACE || b == CH_TAB || b == CH_NL);
  assign inc    = (cur != 8'hFF) ? cur + 8'd1 : cur;
  assign cur9   = {1'b0, cur} + 9'd1;
  assign nm1    = {4'd0, n} - 9'd1;
  assign n_ge2  = (n >= 5'd2);
  assign start9 = (phase == PH_LEAD) ? 9'd0 : cur9;

  // Decode one split step
  logic   d_flush, d_frem, d_emit, d_hclr, d_push, d_sethas, d_rclr, d_rset;
  res_t   d_res;
  phase_t d_ph;
  logic [7:0] d_cur;

  always_comb begin
    logic sn;
    sn       = 1'b0;
    d_flush  = 1'b0;
    d_frem   = 1'b0;
    d_emit   = 1'b0;
    d_hclr   = 1'b0;
    d_push   = 1'b0;
    d_sethas = 1'b0;
    d_rclr   = 1'b0;
    d_rset   = 1'b0;
    d_res    = '{byte_v: 1'b1, fend: 1'b0, data: b, idx: cur};
    d_ph     = phase;
    d_cur    = cur;
    if (n == 5'd1) begin
      // single value: trim white space only
      if (!(phase == PH_LEAD && wh)) begin
        d_ph = PH_FIELD;
        if (wh) begin
          d_push = 1'b1;
        end else begin
          d_flush = 1'b1;
          d_emit  = 1'b1;
        end
      end
    end else if (phase == PH_REM && n_ge2) begin
      if (wh) begin
        d_push = 1'b1;
      end else if (!mem) begin
        d_flush = 1'b1;
        d_frem  = 1'b1;
        d_emit  = 1'b1;
      end else if (hhas || rhas) begin
        d_flush = 1'b1;
        d_frem  = 1'b1;
        d_emit  = 1'b1;
        d_rset  = 1'b1;
      end else begin
        d_push   = 1'b1;
        d_sethas = 1'b1;
      end
    end else begin
      d_hclr = 1'b1;
      unique case (phase)
        PH_LEAD: begin
          if (!wh) begin
            if (!mem) begin
              d_ph   = PH_FIELD;
              d_emit = 1'b1;
            end else begin
              d_res  = '{byte_v: 1'b0, fend: 1'b1, data: 8'd0, idx: cur};
              d_emit = 1'b1;
              d_ph   = PH_SEP2;
            end
          end
        end
        PH_FIELD, PH_REM: begin
          d_ph   = PH_FIELD;
          d_emit = 1'b1;
          if (mem) begin
            d_res = '{byte_v: 1'b0, fend: 1'b1, data: 8'd0, idx: cur};
            d_ph  = wh ? PH_SEP1 : PH_SEP2;
          end
        end
        PH_SEP1: begin
          if (!wh) begin
            if (mem) d_ph = PH_SEP2;
            else     sn   = 1'b1;
          end
        end
        default: begin
          d_ph = PH_SEP2;
          if (!wh) begin
            if (!mem || (n_ge2 && cur9 >= nm1)) begin
              sn = 1'b1;
            end else begin
              d_cur  = inc;
              d_res  = '{byte_v: 1'b0, fend: 1'b1, data: 8'd0, idx: inc};
              d_emit = 1'b1;
            end
          end
        end
      endcase
      // open the next field
      if (sn) begin
        d_cur = inc;
        d_res = '{byte_v: 1'b1, fend: 1'b0, data: b, idx: inc};
        if (n_ge2 && {1'b0, inc} >= nm1) begin
          d_ph   = PH_REM;
          d_rclr = 1'b1;
          if (wh) begin
            d_push = 1'b1;
          end else if (!mem) begin
            d_emit = 1'b1;
          end else begin
            d_push   = 1'b1;
            d_sethas = 1'b1;
          end
        end else begin
          d_ph   = PH_FIELD;
          d_emit = 1'b1;
        end
      end
    end
  end

  // Hold push arithmetic
  logic [5:0] hbase, flush_n;
  assign hbase   = d_hclr ? 6'd0 : hcnt;
  assign flush_n = (hcnt > DEPTH6) ? DEPTH6 : hcnt;

  // End of line marks
  logic em_first, em_pad;
  assign em_first = (n == 5'd1) ||
                    (n == 5'd0 && (phase == PH_FIELD || phase == PH_REM)) ||
                    (n_ge2 && (phase == PH_REM || phase == PH_FIELD));
  assign em_pad   = n_ge2 && (phase != PH_REM) && (start9 < {4'd0, n});

  // Status to the controller
  always_comb begin
    sts.sub_avail  = sa_v || sb_v;
    sts.do_end     = do_end;
    sts.flush_go   = d_flush && (hcnt != 6'd0);
    sts.emit_need  = d_emit;
    sts.slot_ok    = !pend_v || !out_valid || out_ready;
    sts.flush_last = (6'(fptr) == flush_n - 6'd1);
    sts.em_first   = em_first;
    sts.em_pad     = em_pad;
    sts.pad_last   = ({1'b0, pad_f} == n - 5'd1);
  end

  // Escape decode at the transaction
  logic [7:0] a_n;
  logic       av_n, bv_n, esc_n;
  always_comb begin
    a_n   = data_byte;
    av_n  = 1'b0;
    bv_n  = 1'b0;
    esc_n = esc;
    if (!line_end) begin
      if (esc_bypass) begin
        esc_n = 1'b0;
        av_n  = 1'b1;
        if (esc) begin
          a_n  = CH_BSL;
          bv_n = 1'b1;
        end
      end else if (esc) begin
        esc_n = 1'b0;
        av_n  = 1'b1;
        unique case (data_byte)
          CH_LC_N: a_n = CH_NL;
          CH_LC_T: a_n = CH_TAB;
          CH_LC_R: a_n = CH_CR;
          CH_BSL:  a_n = CH_BSL;
          default: begin
            a_n  = CH_BSL;
            bv_n = 1'b1;
          end
        endcase
      end else if (data_byte == CH_BSL) begin
        esc_n = 1'b1;
      end else begin
        av_n = 1'b1;
      end
    end else begin
      a_n   = CH_BSL;
      av_n  = esc;
      esc_n = 1'b0;
    end
  end

  // Line state and sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      esc       <= 1'b0;
      phase     <= PH_LEAD;
      cur       <= 8'd0;
      hcnt      <= 6'd0;
      hhas      <= 1'b0;
      rhas      <= 1'b0;
      sa_v      <= 1'b0;
      sb_v      <= 1'b0;
      do_end    <= 1'b0;
      item_lost <= 1'b0;
    end else if (cmd.accept) begin
      esc       <= esc_n;
      sa_v      <= av_n;
      sb_v      <= bv_n;
      do_end    <= line_end;
      item_lost <= 1'b0;
    end else if (cmd.step_apply) begin
      if (sa_v) sa_v <= 1'b0;
      else      sb_v <= 1'b0;
      phase <= d_ph;
      cur   <= d_cur;
      if (d_push) begin
        hcnt <= (hbase < 6'd63) ? hbase + 6'd1 : hbase;
      end else begin
        hcnt <= (d_hclr || d_flush) ? 6'd0 : hcnt;
      end
      hhas <= ((d_hclr || d_flush) ? 1'b0 : hhas) | d_sethas;
      rhas <= (d_rclr ? 1'b0 : rhas) | d_rset;
    end else if (cmd.flush_start) begin
      item_lost <= item_lost | (hcnt > DEPTH6);
      if (d_frem) rhas <= 1'b1;
    end else if (cmd.flush_emit) begin
      if (sts.flush_last) begin
        hcnt <= 6'd0;
        hhas <= 1'b0;
      end
    end else if ((cmd.end_first && !em_pad) || (cmd.end_pad && sts.pad_last)) begin
      phase <= PH_LEAD;
      cur   <= 8'd0;
      hcnt  <= 6'd0;
      hhas  <= 1'b0;
      rhas  <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sa <= a_n;
      sb <= data_byte;
    end
    if (cmd.step_apply && d_push && hbase < DEPTH6) begin
      hold_mem[hbase[AW-1:0]] <= b;
    end
    if (cmd.flush_start) fptr <= '0;
    else if (cmd.flush_emit) fptr <= fptr + 1'b1;
    if (cmd.end_first) pad_f <= start9[3:0];
    else if (cmd.end_pad) pad_f <= pad_f + 4'd1;
  end

  // Pick the result produced this cycle
  logic emit_go;
  res_t emit_res;
  always_comb begin
    emit_go  = 1'b1;
    emit_res = d_res;
    priority if (cmd.step_apply && d_emit) begin
      emit_res = d_res;
    end else if (cmd.flush_emit) begin
      emit_res = '{byte_v: 1'b1, fend: 1'b0, data: hold_mem[fptr], idx: cur};
    end else if (cmd.end_first && em_first) begin
      emit_res = '{byte_v: 1'b0, fend: 1'b1, data: 8'd0, idx: cur};
    end else if (cmd.end_pad) begin
      emit_res = '{byte_v: 1'b0, fend: 1'b1, data: 8'd0, idx: {4'd0, pad_f}};
    end else begin
      emit_go = 1'b0;
    end
  end

  // Stage one result so that the last one can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else if (emit_go) begin
      pend_v <= 1'b1;
      if (pend_v) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end else if (cmd.release_pend && pend_v) begin
      pend_v    <= 1'b0;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      pend <= emit_res;
      if (pend_v) begin
        out_r    <= pend;
        out_last <= 1'b0;
        out_ovf  <= item_lost;
      end
    end else if (cmd.release_pend && pend_v) begin
      out_r    <= pend;
      out_last <= 1'b1;
      out_ovf  <= item_lost;
    end
  end

  assign out_byte      = out_r.data;
  assign field_index   = out_r.idx;
  assign byte_valid    = out_r.byte_v;
  assign field_end     = out_r.fend;
  assign hold_overflow = out_ovf;
  assign last          = out_last;

endmodule

// ===== hw/rtl/ifs_field_splitter_unit.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    data_byte, line_end
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
// out       output     out_valid / out_ready  out_byte, field_index, byte_valid,
//                                             field_end, hold_overflow, last
//
// One transaction at a time: the sequencer takes it, steps through each decoded
// sub-byte, sees the sub-bytes used up and marks the final result; a hold release
// emits each held byte, and a line end adds its end marks, first and padding.
// Synchronous active-high reset clears the sequencer, configuration, line state
// and valid flags; no clearing pass. cfg_ready is always high. A stalled out
// channel stops the sequencer when a result is due and both stages are full.
module ifs_field_splitter_unit import ifs_pkg::*; #(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
  parameter int MAX_NAMES  = MAX_NAMES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        line_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [7:0]  field_index,
  output logic        byte_valid,
  output logic        field_end,
  output logic        hold_overflow,
  output logic        last
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ifs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ifs_dp #(
    .HOLD_DEPTH (HOLD_DEPTH),
    .MAX_NAMES  (MAX_NAMES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (data_byte),
    .line_end      (line_end),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .field_index   (field_index),
    .byte_valid    (byte_valid),
    .field_end     (field_end),
    .hold_overflow (hold_overflow),
    .last          (last)
  );

endmodule

// ===== hw/rtl/ifs_chk.sv =====
`include "ifs_field_splitter_unit_defines.svh"

module ifs_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [7:0] field_index,
  input logic       byte_valid,
  input logic       field_end,
  input logic       last
);

  // An end mark carries no byte
  `IFS_ASSERT_SAME(a_end_mark, out_valid && field_end, !byte_valid && out_byte == 8'd0, "end mark with byte")

  // A result before the final one means the transaction is still in progress
  `IFS_ASSERT_SAME(a_busy_mid, out_valid && !last, !in_ready, "input taken mid transaction")

  // A taken transaction keeps the input side busy in the cycle after
  `IFS_ASSERT_NEXT(a_seq, in_valid && in_ready, !in_ready, "input taken back to back")

  // A stalled result holds
  `IFS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(field_index) && $stable(last), "stalled result changed")

endmodule

bind ifs_field_splitter_unit ifs_chk u_chk (.*);

// ===== test/tb.sv =====
module tb;
  import ifs_pkg::*;

  typedef struct packed {
    bit [7:0] data;
    bit [7:0] fld;
    bit       bv;
    bit       fe;
    bit       ovf;
    bit       lst;
  } field_res_t;

  // Scoreboard: own copy of the splitter state and registers
  class split_scoreboard;
    bit [63:0]  map [4];
    bit         raw;
    bit [4:0]   ncount;
    bit         esc;
    phase_t     ph;
    int         cur;
    bit [7:0]   hold [32];
    int         hcnt;
    bit         hdel;
    bit         rdel;
    bit         lost;
    field_res_t batch[$];
    field_res_t pending[$];

    function new();
      map[0] = IFS_MAP0_RST;
      map[1] = '0;
      map[2] = '0;
      map[3] = '0;
      raw = 0;
      ncount = 1;
      esc = 0;
      ph = PH_LEAD;
      cur = 0;
      hcnt = 0;
      hdel = 0;
      rdel = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [63:0] val);
      case (idx)
        CFG_MAP0:  map[0] = val;
        CFG_MAP1:  map[1] = val;
        CFG_MAP2:  map[2] = val;
        CFG_MAP3:  map[3] = val;
        CFG_RAW:   raw = val[0];
        CFG_NAMES: ncount = val[4:0];
        default: ;
      endcase
    endfunction

    function void put(bit [7:0] b, int f, bit v, bit e);
      field_res_t r;
      if (batch.size() >= 50) return;
      r.data = v ? b : 8'd0;
      r.fld = f[7:0];
      r.bv = v;
      r.fe = e;
      r.ovf = 0;
      r.lst = 0;
      batch.push_back(r);
    endfunction

    function bit member(bit [7:0] b);
      return map[b[7:6]][b[5:0]];
    endfunction

    function bit white(bit [7:0] b);
      return (b == CH_SPACE || b == CH_TAB || b == CH_NL) && member(b);
    endfunction

    function int names();
      return (ncount > 16) ? 16 : int'(ncount);
    endfunction

    function void hold_push(bit [7:0] b);
      if (hcnt < 32) hold[hcnt] = b;
      if (hcnt < 63) hcnt++;
    endfunction

    function void hold_release();
      int n;
      n = (hcnt < 32) ? hcnt : 32;
      for (int i = 0; i < n; i++) put(hold[i], cur, 1, 0);
      if (hcnt > 32) lost = 1;
      hcnt = 0;
      hdel = 0;
    endfunction

    function void advance();
      if (cur < 255) cur++;
    endfunction

    function void rem_release();
      if (hcnt > 0) rdel = 1;
      hold_release();
    endfunction

    function void rem_byte(bit [7:0] b);
      if (white(b)) hold_push(b);
      else if (!member(b)) begin
        rem_release();
        put(b, cur, 1, 0);
      end else if (hdel || rdel) begin
        rem_release();
        put(b, cur, 1, 0);
        rdel = 1;
      end else begin
        hold_push(b);
        hdel = 1;
      end
    endfunction

    function void open_field(bit [7:0] b, int n);
      advance();
      if (n >= 2 && cur >= n - 1) begin
        ph = PH_REM;
        rdel = 0;
        hcnt = 0;
        hdel = 0;
        rem_byte(b);
      end else begin
        ph = PH_FIELD;
        put(b, cur, 1, 0);
      end
    endfunction

    function void split(bit [7:0] b);
      int n;
      bit wh, mem;
      n = names();
      wh = white(b);
      mem = member(b);
      // Single value: trim white space only
      if (n == 1) begin
        if (ph == PH_LEAD && wh) return;
        ph = PH_FIELD;
        if (wh) hold_push(b);
        else begin
          hold_release();
          put(b, cur, 1, 0);
        end
        return;
      end
      if (ph == PH_REM) begin
        if (n >= 2) begin
          rem_byte(b);
          return;
        end
        ph = PH_FIELD;
      end
      hcnt = 0;
      hdel = 0;
      case (ph)
        PH_LEAD: begin
          if (wh) return;
          if (!mem) begin
            ph = PH_FIELD;
            put(b, cur, 1, 0);
          end else begin
            put(0, cur, 0, 1);
            ph = PH_SEP2;
          end
        end
        PH_FIELD: begin
          if (!mem) put(b, cur, 1, 0);
          else begin
            put(0, cur, 0, 1);
            ph = wh ? PH_SEP1 : PH_SEP2;
          end
        end
        PH_SEP1: begin
          if (wh) return;
          if (mem) ph = PH_SEP2;
          else open_field(b, n);
        end
        default: begin
          ph = PH_SEP2;
          if (wh) return;
          if (!mem || (n >= 2 && cur + 1 >= n - 1)) open_field(b, n);
          else begin
            advance();
            put(0, cur, 0, 1);
          end
        end
      endcase
    endfunction

    function void close_line();
      int n, start;
      n = names();
      if (n == 1) put(0, cur, 0, 1);
      else if (n == 0) begin
        if (ph == PH_FIELD || ph == PH_REM) put(0, cur, 0, 1);
      end else if (ph == PH_REM) put(0, cur, 0, 1);
      else begin
        if (ph == PH_LEAD) start = 0;
        else begin
          if (ph == PH_FIELD) put(0, cur, 0, 1);
          start = cur + 1;
        end
        for (int f = start; f < n; f++) put(0, f, 0, 1);
      end
      esc = 0;
      ph = PH_LEAD;
      cur = 0;
      hcnt = 0;
      hdel = 0;
      rdel = 0;
    endfunction

    // Note an accepted input transaction and queue the fields it yields
    function void note_input(bit [7:0] b, bit le);
      batch.delete();
      lost = 0;
      if (!le) begin
        if (raw) begin
          if (esc) begin
            esc = 0;
            split(CH_BSL);
          end
          split(b);
        end else if (esc) begin
          esc = 0;
          case (b)
            CH_LC_N: split(CH_NL);
            CH_LC_T: split(CH_TAB);
            CH_LC_R: split(CH_CR);
            CH_BSL:  split(CH_BSL);
            default: begin
              split(CH_BSL);
              split(b);
            end
          endcase
        end else if (b == CH_BSL) esc = 1;
        else split(b);
      end else begin
        if (esc) begin
          esc = 0;
          split(CH_BSL);
        end
        close_line();
      end
      foreach (batch[k]) begin
        batch[k].ovf = lost;
        batch[k].lst = (k == batch.size() - 1);
        pending.push_back(batch[k]);
      end
    endfunction

    // Compare one output transaction with the oldest expected field result
    function bit check_result(field_res_t got, output string msg);
      field_res_t w;
      if (pending.size() == 0) begin
        msg = $sformatf("unexpected result byte=%h idx=%0d", got.data, got.fld);
        return 0;
      end
      w = pending.pop_front();
      if (got != w) begin
        msg = $sformatf("got b=%h i=%0d bv=%b fe=%b ov=%b l=%b, want b=%h i=%0d bv=%b fe=%b ov=%b l=%b",
                        got.data, got.fld, got.bv, got.fe, got.ovf, got.lst,
                        w.data, w.fld, w.bv, w.fe, w.ovf, w.lst);
        return 0;
      end
      msg = "";
      return 1;
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        line_end = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [7:0]  out_byte;
  logic [7:0]  field_index;
  logic        byte_valid;
  logic        field_end;
  logic        hold_overflow;
  logic        last;

  split_scoreboard sb = new();
  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  bit  idle_on = 1;
  bit  long_hold = 0;

  ifs_field_splitter_unit dut (.*);

  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("ifs_field_splitter_unit regression: fail");
    $finish;
  end

  task automatic report(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Offer one input transaction, with a random gap first
  task automatic send_item(bit [7:0] b, bit le);
    int g;
    g = idle_on ? $urandom_range(0, 8) : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    data_byte <= b;
    line_end <= le;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b, le);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(string s, bit close = 1);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 0);
    if (close) send_item(8'($urandom_range(0, 255)), 1);
  endtask

  // Hold input until every expected result is out and the block is quiet
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_cfg(bit [2:0] idx, bit [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic random_config(int mode);
    bit [63:0] m0;
    m0 = {$urandom, $urandom};
    if ($urandom_range(0, 1)) m0 |= IFS_MAP0_RST;
    m0[58] = $urandom_range(0, 1);
    m0[44] = $urandom_range(0, 1);
    case (mode)
      0: begin
        write_cfg(CFG_MAP0, '1);
        write_cfg(CFG_MAP1, '1);
        write_cfg(CFG_MAP2, '1);
        write_cfg(CFG_MAP3, '1);
      end
      1: begin
        write_cfg(CFG_MAP0, '0);
        write_cfg(CFG_MAP1, '0);
        write_cfg(CFG_MAP2, '0);
        write_cfg(CFG_MAP3, '0);
      end
      default: begin
        write_cfg(CFG_MAP0, m0);
        write_cfg(CFG_MAP1, {$urandom, $urandom} & {$urandom, $urandom});
        write_cfg(CFG_MAP2, {$urandom, $urandom} & {$urandom, $urandom});
        write_cfg(CFG_MAP3, {$urandom, $urandom} & {$urandom, $urandom});
      end
    endcase
    write_cfg(CFG_RAW, {$urandom, $urandom});
    case ($urandom_range(0, 7))
      0: write_cfg(CFG_NAMES, 0);
      1: write_cfg(CFG_NAMES, 1);
      2: write_cfg(CFG_NAMES, 2);
      3: write_cfg(CFG_NAMES, 3);
      4: write_cfg(CFG_NAMES, 16);
      5: write_cfg(CFG_NAMES, 31);
      default: write_cfg(CFG_NAMES, {$urandom, $urandom});
    endcase
  endtask

  function automatic bit [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5: return 8'h61 + 8'($urandom_range(0, 25));
      6, 7:  return CH_SPACE;
      8:     return CH_TAB;
      9:     return 8'h3A;
      10:    return 8'h2C;
      11:    return CH_BSL;
      12:    return $urandom_range(0, 1) ? CH_LC_N : ($urandom_range(0, 1) ? CH_LC_T : CH_LC_R);
      13:    return CH_NL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receive side: random stalls, one long hold on request
  initial begin
    int g;
    field_res_t got;
    string msg;
    forever begin
      @(negedge clk);
      g = long_hold ? 300 : (idle_on ? $urandom_range(0, 8) : 0);
      long_hold = 0;
      if (g > 0) begin
        out_ready <= 0;
        repeat (g) @(negedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      got.data = out_byte;
      got.fld = field_index;
      got.bv = byte_valid;
      got.fe = field_end;
      got.ovf = hold_overflow;
      got.lst = last;
      results_seen++;
      if (!sb.check_result(got, msg)) report(msg);
    end
  end

  // Stimulus
  initial begin
    int n;
    string s;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Single value with reset delimiters, escapes, byte extremes
    send_line("  ab\tc  ");
    send_line("a\\nb\\tc\\rd\\\\e\\qf\\");
    send_item(8'h00, 0);
    send_item(8'hFF, 0);
    send_item(8'hFF, 1);
    send_line("");
    // Hold overflow: long white run inside the value
    s = "a";
    for (int i = 0; i < 40; i++) s = {s, " "};
    send_line({s, "b"});
    drain();

    // Array mode with a non-white delimiter
    write_cfg(CFG_MAP0, IFS_MAP0_RST | (64'd1 << 58));
    write_cfg(CFG_NAMES, 0);
    send_line(" a::b  c : ");
    send_line("");
    drain();
    // Three names and the remainder rule
    write_cfg(CFG_NAMES, 3);
    send_line("x y z w");
    send_line("a:b:c:");
    send_line("a b c :");
    send_line("");
    // Line mode change between transactions
    send_line("a b", 0);
    drain();
    write_cfg(CFG_NAMES, 1);
    send_line(" c ");
    // Raw mode turned on with an escape pending
    send_line("a\\", 0);
    drain();
    write_cfg(CFG_RAW, 1);
    send_line("n\\t");
    drain();

    // Random lines under several settings
    for (int p = 0; p < 8; p++) begin
      drain();
      random_config(p);
      idle_on = (p != 3);
      n = 0;
      while (n < 8) begin
        if (p == 5 && n == 0) long_hold = 1;
        if ($urandom_range(0, 19) == 0) begin
          for (int i = 0; i < 36; i++) send_item(CH_SPACE, 0);
          n += 36;
        end
        for (int i = $urandom_range(0, 10); i > 0; i--) begin
          send_item(pick_byte(), 0);
          n++;
        end
        if ($urandom_range(0, 7) != 0) begin
          send_item(8'($urandom_range(0, 255)), 1);
          n++;
        end
      end
    end
    drain();
    write_cfg(CFG_MAP0, IFS_MAP0_RST);
    write_cfg(CFG_RAW, 0);
    write_cfg(CFG_NAMES, 1);
    send_line(" end ");

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d input transactions and %0d results across array, single,",
             items_sent, results_seen);
    $display("named, raw and escape modes with full and empty delimiter sets");
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("ifs_field_splitter_unit regression: pass");
    end else begin
      $display("ifs_field_splitter_unit regression: fail");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ifs_pkg.sv
hw/rtl/ifs_ctrl.sv
hw/rtl/ifs_dp.sv
hw/rtl/ifs_field_splitter_unit.sv
hw/rtl/ifs_chk.sv
test/tb.sv
